/* src/mrs_pkg.sv */
// Shared types and constants for the MPU region range splitter.
package mrs_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned LOG2_W     = 5;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned MAX_RUN    = 64;
   localparam int unsigned RUN_CNT_W  = 6;
   localparam int unsigned CSR_ADDR_W = 3;

   // Alignment modes; the unused code behaves as no alignment.
   localparam logic [MODE_W-1:0] MODE_ROUND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRUNC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd2;

   // 256 KiB truncation mask.
   localparam logic [DATA_W-1:0] DEV_MASK = 32'hFFFC_0000;

   localparam logic [LOG2_W-1:0] MIN_PAGE_RESET = 5'd8;

   // Register index of min_page_log2 (byte address bit 2 selects the word).
   localparam logic REG_MIN_PAGE = 1'b0;

   typedef struct packed {
      logic load;   // capture and align a new range
      logic emit;   // write one result beat into the output register
   } cmd_type;

   typedef struct packed {
      logic last;   // the beat about to be emitted ends the run
   } sts_type;

endpackage

/* src/mpu_region_range_split.sv */
// Top level of the MPU region range splitter: register port, controller and datapath.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  range_base, range_length, align_mode
//   rsp_      out        rsp_valid/rsp_ready  region_base, region_log2, status, last
//   csr_      in/out     APB psel/penable     min_page_log2 at byte address 0
//
// A range is accepted in S_IDLE, then the region walk produces one region beat per
// cycle while the output register is empty or rsp_ready is high; a run has at most
// 64 beats, and an empty aligned range gives one beat.
// The output register frees the input side: a new range is taken while the
// last beat of the previous run still waits. Synchronous reset clears the
// controller and sets min_page_log2 to 8.
module mpu_region_range_split #(
   parameter int unsigned ADDR_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mrs_pkg::DATA_W-1:0]        req_range_base,
   input  logic [mrs_pkg::DATA_W-1:0]        req_range_length,
   input  logic [mrs_pkg::MODE_W-1:0]        req_align_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mrs_pkg::DATA_W-1:0]        rsp_region_base,
   output logic [mrs_pkg::LOG2_W-1:0]        rsp_region_log2,
   output logic                              rsp_status,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mrs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mrs_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [mrs_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import mrs_pkg::*;

   logic [LOG2_W-1:0] min_page_ff, min_page_in;
   logic              csr_wr;
   cmd_type           cmd;
   sts_type           sts;

   // Register port: pready is held high; bit 2 of the byte address picks the word.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      min_page_in = min_page_ff;
      if (csr_wr && (csr_paddr[2] == REG_MIN_PAGE)) begin
         min_page_in = csr_pwdata[LOG2_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_MIN_PAGE) begin
         csr_prdata = DATA_W'(min_page_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_page_ff <= MIN_PAGE_RESET;
      end else begin
         min_page_ff <= min_page_in;
      end
   end

   // Sequence runs and hold result beats until taken.
   mrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Align the range and walk it one region per emitted beat.
   mrs_dpath #(
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock         (clock),
      .cmd           (cmd),
      .sts           (sts),
      .min_page_log2 (min_page_ff),
      .range_base    (req_range_base),
      .range_length  (req_range_length),
      .align_mode    (req_align_mode),
      .region_base   (rsp_region_base),
      .region_log2   (rsp_region_log2),
      .status        (rsp_status),
      .last          (rsp_last)
   );

endmodule

/* src/mrs_ctrl.sv */
// Controller for the region splitter: run sequencing and output handshake.
module mrs_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  mrs_pkg::sts_type sts,
   output mrs_pkg::cmd_type cmd
);
   import mrs_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (sts.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> slot_free)
      else $error("beat emitted over an untaken result");
   a_load_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_RUN) && !req_ready)
      else $error("accepted range did not start a run");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.last) |=> (state_ff == S_IDLE) && out_valid_ff)
      else $error("run did not end after final beat");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.emit))
      else $error("load and emit in the same cycle");
`endif

endmodule

/* src/mrs_dpath.sv */
// Datapath for the region splitter: alignment, region walk and output register.
module mrs_dpath #(
   parameter int unsigned ADDR_BITS = 32
) (
   input  logic                          clock,
   input  mrs_pkg::cmd_type              cmd,
   output mrs_pkg::sts_type              sts,
   input  logic [mrs_pkg::LOG2_W-1:0]    min_page_log2,
   input  logic [mrs_pkg::DATA_W-1:0]    range_base,
   input  logic [mrs_pkg::DATA_W-1:0]    range_length,
   input  logic [mrs_pkg::MODE_W-1:0]    align_mode,
   output logic [mrs_pkg::DATA_W-1:0]    region_base,
   output logic [mrs_pkg::LOG2_W-1:0]    region_log2,
   output logic                          status,
   output logic                          last
);
   import mrs_pkg::*;

   // Trailing-zero count; an all-zero word counts as ADDR_BITS-1.
   function automatic logic [LOG2_W-1:0] tz_count(input logic [ADDR_BITS-1:0] x);
      logic [LOG2_W-1:0] r;
      r = LOG2_W'(ADDR_BITS - 1);
      for (int i = ADDR_BITS - 1; i >= 0; i--) begin
         if (x[i]) r = LOG2_W'(i);
      end
      return r;
   endfunction

   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [ADDR_BITS-1:0] len_ff, len_in;
   logic [RUN_CNT_W-1:0] cnt_ff, cnt_in;

   logic [ADDR_BITS-1:0] raw_base, raw_len;
   logic [ADDR_BITS-1:0] gran, gran_mask, trunc_mask;
   logic [ADDR_BITS-1:0] al_base, al_len;

   logic [LOG2_W-1:0]    base_tz, len_tz, sh;
   logic [ADDR_BITS-1:0] base_pow, step, len_next;
   logic                 len_zero, run_last;

   logic [DATA_W-1:0]    rb_ff, rb_in;
   logic [LOG2_W-1:0]    rl_ff, rl_in;
   logic                 st_ff, st_in;
   logic                 lst_ff, lst_in;

   // Alignment of the incoming range; a granule at or above ADDR_BITS
   // shifts out to zero, which rounds every value to zero.
   always_comb begin
      raw_base   = range_base[ADDR_BITS-1:0];
      raw_len    = range_length[ADDR_BITS-1:0];
      gran       = ADDR_BITS'(1) << min_page_log2;
      gran_mask  = gran - ADDR_BITS'(1);
      trunc_mask = DEV_MASK[ADDR_BITS-1:0];
      case (align_mode)
         MODE_ROUND: begin
            al_base = (raw_base & ~gran_mask) + (((raw_base & gran_mask) != '0) ? gran : '0);
            al_len  = (raw_len & ~gran_mask) + (((raw_len & gran_mask) != '0) ? gran : '0);
         end
         MODE_TRUNC: begin
            al_base = raw_base & trunc_mask;
            al_len  = raw_len & trunc_mask;
         end
         default: begin
            al_base = raw_base;
            al_len  = raw_len;
         end
      endcase
   end

   // One region per step.
   always_comb begin
      base_tz  = tz_count(base_ff);
      len_tz   = tz_count(len_ff);
      base_pow = ADDR_BITS'(1) << base_tz;
      sh       = (base_pow > len_ff) ? len_tz : base_tz;
      step     = ADDR_BITS'(1) << sh;
      len_next = len_ff - step;
      len_zero = (len_ff == '0);
      run_last = (len_next == '0) || (cnt_ff == RUN_CNT_W'(MAX_RUN - 1));
   end

   assign sts.last = len_zero || run_last;

   always_comb begin
      base_in = base_ff;
      len_in  = len_ff;
      cnt_in  = cnt_ff;
      rb_in   = rb_ff;
      rl_in   = rl_ff;
      st_in   = st_ff;
      lst_in  = lst_ff;
      if (cmd.load) begin
         base_in = al_base;
         len_in  = al_len;
         cnt_in  = '0;
      end else if (cmd.emit) begin
         if (len_zero) begin
            rb_in  = '0;
            rl_in  = '0;
            st_in  = 1'b1;
            lst_in = 1'b1;
         end else begin
            rb_in   = DATA_W'(base_ff);
            rl_in   = sh;
            st_in   = 1'b0;
            lst_in  = run_last;
            base_in = base_ff + step;
            len_in  = len_next;
            cnt_in  = cnt_ff + RUN_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      rb_ff   <= rb_in;
      rl_ff   <= rl_in;
      st_ff   <= st_in;
      lst_ff  <= lst_in;
   end

   assign region_base = rb_ff;
   assign region_log2 = rl_ff;
   assign status      = st_ff;
   assign last        = lst_ff;

endmodule
